// ----- design/itaf_pkg.sv -----
// Shared types, character codes and lookup functions for the integer to
// ASCII formatter. No dependencies.
package itaf_pkg;

  // Input mode codes
  localparam logic [2:0] MODE_SDEC  = 3'd0;
  localparam logic [2:0] MODE_UDEC  = 3'd1;
  localparam logic [2:0] MODE_HEXLO = 3'd2;
  localparam logic [2:0] MODE_HEXUP = 3'd3;
  localparam logic [2:0] MODE_PTR   = 3'd4;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DIGIT_N  = 16;
  localparam int unsigned NIL_LEN  = 5;

  // n / 10 == (n * RECIP10) >> 35 for every 32-bit n
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SH = 35;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [1:0] {
    KIND_DEC,
    KIND_HEX,
    KIND_NIL
  } kind_e;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_0X
  } prefix_e;

  typedef struct packed {
    kind_e              kind;
    prefix_e            prefix;
    logic               upper;
    logic [VALUE_W-1:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIGITS,
    BK_EMIT
  } bk_state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    case (d)
      4'd10:   c = upper ? 8'h41 : 8'h61;
      4'd11:   c = upper ? 8'h42 : 8'h62;
      4'd12:   c = upper ? 8'h43 : 8'h63;
      4'd13:   c = upper ? 8'h44 : 8'h64;
      4'd14:   c = upper ? 8'h45 : 8'h65;
      4'd15:   c = upper ? 8'h46 : 8'h66;
      default: c = CH_ZERO + {4'd0, d};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;  // (
      3'd1:    c = 8'h6E;  // n
      3'd2:    c = 8'h69;  // i
      3'd3:    c = 8'h6C;  // l
      default: c = 8'h29;  // )
    endcase
    return c;
  endfunction

endpackage

// ----- design/integer_to_ascii_formatter_top.sv -----
// Top level of the integer to ASCII formatter: front end, job queue and
// back end. Depends on itaf_pkg, itaf_front, itaf_queue, itaf_back.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          mode_i, value_i
// result    out        empty / pop          character_o, last_o, char_count_o
//
// An item leaves the queue, then goes through digit extraction (one digit
// per cycle from the divide-by-ten / nibble-shift unit, up to 16 digits) and
// emission (one character per cycle while the result is not stalled, up to 18).
// "(nil)" skips extraction. Undefined modes are taken and dropped.
// Reset is asynchronous, active low; the queue and result register empty.
// A stalled result holds the back end; the two-entry queue keeps the input
// accepting meanwhile until it is full.
module integer_to_ascii_formatter_top import itaf_pkg::*; #(
  parameter int unsigned POINTER_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         mode_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         character_o,
  output logic               last_o,
  output logic [CNT_W-1:0]   char_count_o
);

  logic job_valid, job_empty, job_pop;
  job_t front_job, back_job;

  // classify on the transfer itself; the queue registers the descriptor
  itaf_front #(
    .POINTER_WIDTH(POINTER_WIDTH)
  ) u_front (
    .push_ok_i  (push && !full),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .job_valid_o(job_valid),
    .job_o      (front_job)
  );

  itaf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .job_i  (front_job),
    .full_o (full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .job_o  (back_job)
  );

  itaf_back #(
    .POINTER_WIDTH(POINTER_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .character_o (character_o),
    .last_o      (last_o),
    .char_count_o(char_count_o)
  );

endmodule

// ----- design/itaf_front.sv -----
// Front end: classifies an accepted item into a job descriptor.
// Depends on itaf_pkg.
module itaf_front import itaf_pkg::*; #(
  parameter int unsigned POINTER_WIDTH = 64
) (
  input  logic               push_ok_i,
  input  logic [2:0]         mode_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               job_valid_o,
  output job_t               job_o
);

  logic [31:0]              low;
  logic [POINTER_WIDTH-1:0] ptr;

  assign low = value_i[31:0];
  assign ptr = value_i[POINTER_WIDTH-1:0];

  always_comb begin
    job_valid_o  = push_ok_i;
    job_o.kind   = KIND_HEX;
    job_o.prefix = PFX_NONE;
    job_o.upper  = 1'b0;
    job_o.mag    = VALUE_W'(low);
    case (mode_i)
      MODE_SDEC: begin
        job_o.kind = KIND_DEC;
        if (low[31]) begin
          job_o.prefix = PFX_MINUS;
          job_o.mag    = VALUE_W'(32'(32'd0 - low));
        end
      end
      MODE_UDEC:  job_o.kind = KIND_DEC;
      MODE_HEXLO: job_o.kind = KIND_HEX;
      MODE_HEXUP: job_o.upper = 1'b1;
      MODE_PTR: begin
        job_o.mag = VALUE_W'(ptr);
        if (ptr == '0) begin
          job_o.kind = KIND_NIL;
        end else begin
          job_o.prefix = PFX_0X;
        end
      end
      default: job_valid_o = 1'b0;  // undefined modes produce nothing
    endcase
  end

endmodule

// ----- design/itaf_queue.sv -----
// Two-entry job queue between the front and back ends.
// Depends on itaf_pkg.
module itaf_queue import itaf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = 2'(cnt_q + 2'd1);
    end else if (do_pop && !do_push) begin
      cnt_d = 2'(cnt_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ----- design/itaf_back.sv -----
// Back end: digit extraction into a LIFO, then character emission into
// the output register. Depends on itaf_pkg.
module itaf_back import itaf_pkg::*; #(
  parameter int unsigned POINTER_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_empty_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       character_o,
  output logic             last_o,
  output logic [CNT_W-1:0] char_count_o
);

  bk_state_e                state_q, state_d;
  kind_e                    kind_q, kind_d;
  prefix_e                  prefix_q, prefix_d;
  logic                     upper_q, upper_d;
  logic [POINTER_WIDTH-1:0] work_q, work_d;
  logic [3:0]               stk_q [DIGIT_N];
  logic [CNT_W-1:0]         total_q, total_d;
  logic [CNT_W-1:0]         emit_q, emit_d;
  logic                     ov_q, ov_d;
  logic [7:0]               ch_q, ch_d;
  logic                     last_q, last_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic [63:0]              prod;
  logic [28:0]              quot;
  logic [31:0]              rem;
  logic [3:0]               dig;
  logic [POINTER_WIDTH-1:0] next_w;
  logic                     dig_done;
  logic [CNT_W-1:0]         pre_len, chars_total;
  logic                     out_free, emit_go, emit_last, emit_digit;
  logic                     push_stk, pop_stk;

  // divide by ten by reciprocal, remainder by back-multiply
  assign prod = 64'(work_q[31:0]) * 64'(RECIP10);
  assign quot = prod[63:RECIP_SH];
  assign rem  = work_q[31:0] - 32'({quot, 3'b000}) - 32'({quot, 1'b0});

  always_comb begin
    if (kind_q == KIND_DEC) begin
      dig    = rem[3:0];
      next_w = POINTER_WIDTH'(quot);
    end else begin
      dig    = work_q[3:0];
      next_w = work_q >> 4;
    end
  end

  assign dig_done = (next_w == '0) || (total_q == CNT_W'(DIGIT_N - 1));

  always_comb begin
    case (prefix_q)
      PFX_MINUS: pre_len = CNT_W'(1);
      PFX_0X:    pre_len = CNT_W'(2);
      default:   pre_len = '0;
    endcase
  end

  assign chars_total = (kind_q == KIND_NIL) ? CNT_W'(NIL_LEN) : CNT_W'(pre_len + total_q);
  assign out_free    = !ov_q || pop_i;
  assign emit_go     = (state_q == BK_EMIT) && out_free;
  assign emit_last   = emit_q == CNT_W'(chars_total - CNT_W'(1));
  assign emit_digit  = (kind_q != KIND_NIL) && (emit_q >= pre_len);
  assign push_stk    = state_q == BK_DIGITS;
  assign pop_stk     = emit_go && emit_digit;
  assign job_pop_o   = (state_q == BK_IDLE) && !job_empty_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          state_d = (job_i.kind == KIND_NIL) ? BK_EMIT : BK_DIGITS;
        end
      end
      BK_DIGITS: if (dig_done) state_d = BK_EMIT;
      BK_EMIT:   if (out_free && emit_last) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    kind_d   = kind_q;
    prefix_d = prefix_q;
    upper_d  = upper_q;
    work_d   = work_q;
    total_d  = total_q;
    emit_d   = emit_q;
    ch_d     = ch_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    ov_d     = pop_i ? 1'b0 : ov_q;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i) begin
          kind_d   = job_i.kind;
          prefix_d = job_i.prefix;
          upper_d  = job_i.upper;
          work_d   = job_i.mag[POINTER_WIDTH-1:0];
          total_d  = '0;
          emit_d   = '0;
        end
      end
      BK_DIGITS: begin
        work_d  = next_w;
        total_d = CNT_W'(total_q + CNT_W'(1));
      end
      BK_EMIT: begin
        if (out_free) begin
          ov_d   = 1'b1;
          emit_d = CNT_W'(emit_q + CNT_W'(1));
          last_d = emit_last;
          cnt_d  = emit_last ? chars_total : '0;
          if (kind_q == KIND_NIL) begin
            ch_d = nil_char(emit_q[2:0]);
          end else if (emit_digit) begin
            ch_d = hex_char(stk_q[0], upper_q);
          end else if (prefix_q == PFX_MINUS) begin
            ch_d = CH_MINUS;
          end else begin
            ch_d = (emit_q == '0) ? CH_ZERO : CH_X;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      total_q <= '0;
      emit_q  <= '0;
      work_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      total_q <= total_d;
      emit_q  <= emit_d;
      work_q  <= work_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    prefix_q <= prefix_d;
    upper_q  <= upper_d;
    ch_q     <= ch_d;
    last_q   <= last_d;
    cnt_q    <= cnt_d;
  end

  // digit LIFO: push shifts towards the tail, pop shifts towards the head
  always_ff @(posedge clk_i) begin
    if (push_stk) begin
      stk_q[0] <= dig;
      for (int i = 1; i < DIGIT_N; i++) begin
        stk_q[i] <= stk_q[i-1];
      end
    end else if (pop_stk) begin
      for (int i = 0; i < DIGIT_N - 1; i++) begin
        stk_q[i] <= stk_q[i+1];
      end
    end
  end

  assign empty_o      = !ov_q;
  assign character_o  = ch_q;
  assign last_o       = last_q;
  assign char_count_o = cnt_q;

endmodule

// ----- design/itaf_checker.sv -----
// Port-level checks for the integer to ASCII formatter, bound to the top.
// Depends on itaf_pkg and integer_to_ascii_formatter_top.
module itaf_checker import itaf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         character_o,
  input logic               last_o,
  input logic [CNT_W-1:0]   char_count_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(character_o) && $stable(last_o)
                          && $stable(char_count_o)))
    else $error("result changed while stalled");

  a_count_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_o) |-> (char_count_o == '0))
    else $error("count on a non-final character");

  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_o) |-> (char_count_o != '0 && char_count_o <= CNT_W'(18)))
    else $error("final count out of range");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("not empty in reset");

endmodule

bind integer_to_ascii_formatter_top itaf_checker u_itaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .character_o (character_o),
  .last_o      (last_o),
  .char_count_o(char_count_o)
);
